// ----- rtl/core/pab_pkg.sv -----
// Package for the pixel alpha blend block: widths, shared structs and the
// divide-by-255 helper. No dependencies.
package pab_pkg;

    localparam int CH_W       = 8;
    localparam int LANES      = 3;
    localparam int PROD_W     = 2 * CH_W;
    localparam int NUM_W      = 3 * CH_W;
    localparam int DEN_W      = 2 * CH_W;
    localparam int Q_W        = CH_W + 1;
    localparam int DIV_STAGES = Q_W;

    localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

    // Shared values for the lanes, valid in the product stage
    typedef struct packed {
        logic              opaque;
        logic [PROD_W-1:0] ta;
    } shared_t;

    // Alpha result carried alongside the lane dividers
    typedef struct packed {
        logic            zero;
        logic [CH_W-1:0] ac;
    } alpha_info_t;

    // Exact floor(x / 255) for x up to 255 * 255
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] s;
        s = {1'b0, x} + {{(CH_W + 1){1'b0}}, x[PROD_W-1:CH_W]} + {{PROD_W{1'b0}}, 1'b1};
        return s[PROD_W-1:CH_W];
    endfunction

endpackage

// ----- rtl/core/pixel_alpha_blend.sv -----
// Pixel alpha blend: blends a foreground RGBA pixel over a background pixel.
// Channels: input (in_valid / in_ready) carries the two pixels and mix_alpha,
// output (out_valid / out_ready) carries the blended RGBA pixel. A transfer
// happens when valid and ready are both high at a rising edge of clk.
// Throughput: one pixel per cycle while the receiver does not
// stall; the pipeline is a product stage, a numerator stage, a
// 9-stage restoring divider (one quotient bit per stage), and
// the output register that merges the three color lanes with alpha.
// Opaque pixels run the same divider with a fixed divisor of 255.
// Reset (rst_n low, asynchronous) empties the pipeline and clears out_valid.
// When the receiver stalls, the whole pipeline holds and in_ready drops;
// in_ready is high whenever the output register is empty or being taken.
// Depends on pab_pkg, pab_alpha and pab_lane.
module pixel_alpha_blend (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] bg_red,
    input  logic [7:0] bg_green,
    input  logic [7:0] bg_blue,
    input  logic [7:0] bg_alpha,
    input  logic [7:0] fg_red,
    input  logic [7:0] fg_green,
    input  logic [7:0] fg_blue,
    input  logic [7:0] fg_alpha,
    input  logic [7:0] mix_alpha,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha
);
    import pab_pkg::*;

    localparam int PIPE = DIV_STAGES + 2;

    logic              adv;
    logic [PIPE-1:0]   vld_reg;
    logic              out_valid_reg;
    logic [CH_W-1:0]   fg_ch [0:LANES-1];
    logic [CH_W-1:0]   bg_ch [0:LANES-1];
    logic [Q_W-1:0]    quo   [0:LANES-1];
    logic [CH_W-1:0]   res_reg [0:LANES-1];
    logic [CH_W-1:0]   alpha_reg;
    shared_t           shr;
    logic [DEN_W-1:0]  den;
    alpha_info_t       info;

    // Whole pipeline moves when the output register can take a result
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    assign fg_ch[0] = fg_red;
    assign fg_ch[1] = fg_green;
    assign fg_ch[2] = fg_blue;
    assign bg_ch[0] = bg_red;
    assign bg_ch[1] = bg_green;
    assign bg_ch[2] = bg_blue;

    pab_alpha u_alpha (
        .clk      (clk),
        .adv      (adv),
        .bg_alpha (bg_alpha),
        .fg_alpha (fg_alpha),
        .shr      (shr),
        .den      (den),
        .info     (info)
    );

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        pab_lane u_lane (
            .clk (clk),
            .adv (adv),
            .f   (fg_ch[l]),
            .b   (bg_ch[l]),
            .fa  (fg_alpha),
            .mix (mix_alpha),
            .shr (shr),
            .den (den),
            .quo (quo[l])
        );
    end

    // Track valid pixels through the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[PIPE-2:0], in_valid};
            out_valid_reg <= vld_reg[PIPE-1];
        end
    end

    // Merge lanes: saturate, zero on empty coverage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (info.zero)
                    res_reg[l] <= '0;
                else if (quo[l][Q_W-1])
                    res_reg[l] <= CH_MAX;
                else
                    res_reg[l] <= quo[l][CH_W-1:0];
            end
            alpha_reg <= info.ac;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = res_reg[0];
    assign out_green = res_reg[1];
    assign out_blue  = res_reg[2];
    assign out_alpha = alpha_reg;

endmodule

// ----- rtl/core/pab_alpha.sv -----
// Alpha unit of the pixel alpha blend block: over-alpha, divisor and the
// alpha delay line that tracks the lane dividers. Depends on pab_pkg.
module pab_alpha (
    input  logic                          clk,
    input  logic                          adv,
    input  logic [pab_pkg::CH_W-1:0]      bg_alpha,
    input  logic [pab_pkg::CH_W-1:0]      fg_alpha,
    output pab_pkg::shared_t              shr,
    output logic [pab_pkg::DEN_W-1:0]     den,
    output pab_pkg::alpha_info_t          info
);
    import pab_pkg::*;

    logic [PROD_W-1:0] ta_reg;
    logic              opaque_reg;
    logic [CH_W-1:0]   fa_reg;
    logic [CH_W-1:0]   ac;
    logic [DEN_W+CH_W-1:0] den_full;
    alpha_info_t       info_reg [0:DIV_STAGES];
    alpha_info_t       info_next;

    // Product stage: background share of the coverage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ta_reg     <= PROD_W'((CH_MAX - fg_alpha) * bg_alpha);
            opaque_reg <= (bg_alpha == CH_MAX) && (fg_alpha == CH_MAX);
            fa_reg     <= fg_alpha;
        end
    end

    assign shr.opaque = opaque_reg;
    assign shr.ta     = ta_reg;

    // Combined alpha and divisor; opaque pixels divide by 255
    always_comb
    begin
        ac        = fa_reg + div255(ta_reg);
        den_full  = ({ac, {DEN_W{1'b0}}} >> CH_W) - {{DEN_W{1'b0}}, ac};
        den       = opaque_reg ? DEN_W'(CH_MAX) : den_full[DEN_W-1:0];
        info_next.zero = !opaque_reg && (ac == '0);
        info_next.ac   = opaque_reg ? CH_MAX : ac;
    end

    // Delay line matching the divider depth
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            info_reg[0] <= info_next;
            for (int i = 1; i <= DIV_STAGES; i++)
            begin
                info_reg[i] <= info_reg[i-1];
            end
        end
    end

    assign info = info_reg[DIV_STAGES];

endmodule

// ----- rtl/core/pab_lane.sv -----
// One color lane of the pixel alpha blend block: products, numerator and a
// pipelined restoring divider, one quotient bit per stage. Depends on pab_pkg.
module pab_lane (
    input  logic                          clk,
    input  logic                          adv,
    input  logic [pab_pkg::CH_W-1:0]      f,
    input  logic [pab_pkg::CH_W-1:0]      b,
    input  logic [pab_pkg::CH_W-1:0]      fa,
    input  logic [pab_pkg::CH_W-1:0]      mix,
    input  pab_pkg::shared_t              shr,
    input  logic [pab_pkg::DEN_W-1:0]     den,
    output logic [pab_pkg::Q_W-1:0]       quo
);
    import pab_pkg::*;

    logic [PROD_W-1:0] p_reg;
    logic [PROD_W-1:0] omix_reg;
    logic [CH_W-1:0]   b_reg;
    logic [NUM_W:0]    num_sum;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  rem_reg [0:DIV_STAGES];
    logic [DEN_W-1:0]  den_reg [0:DIV_STAGES];
    logic [Q_W-1:0]    q_reg   [0:DIV_STAGES];
    logic [NUM_W-1:0]  rem_next [1:DIV_STAGES];
    logic [Q_W-1:0]    q_next   [1:DIV_STAGES];

    // Product stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg    <= PROD_W'(fa * f);
            omix_reg <= PROD_W'(mix * f + (CH_MAX - mix) * b);
            b_reg    <= b;
        end
    end

    // Numerator: 255*fa*f + ta*b, or the opaque mix
    always_comb
    begin
        num_sum = ({{(NUM_W + 1 - PROD_W){1'b0}}, p_reg} << CH_W)
                - {{(NUM_W + 1 - PROD_W){1'b0}}, p_reg}
                + (NUM_W + 1)'(shr.ta * b_reg);
        num = shr.opaque ? {{(NUM_W - PROD_W){1'b0}}, omix_reg} : num_sum[NUM_W-1:0];
    end

    // Restoring divide steps, most significant quotient bit first
    always_comb
    begin
        for (int j = 1; j <= DIV_STAGES; j++)
        begin
            logic [NUM_W+Q_W-1:0] trial;
            trial = {{(NUM_W + Q_W - DEN_W){1'b0}}, den_reg[j-1]} << (Q_W - j);
            if ({{Q_W{1'b0}}, rem_reg[j-1]} >= trial)
            begin
                rem_next[j] = rem_reg[j-1] - trial[NUM_W-1:0];
                q_next[j]   = q_reg[j-1] | (Q_W'(1) << (Q_W - j));
            end
            else
            begin
                rem_next[j] = rem_reg[j-1];
                q_next[j]   = q_reg[j-1];
            end
        end
    end

    // Advance the divider pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            for (int j = 1; j <= DIV_STAGES; j++)
            begin
                rem_reg[j] <= rem_next[j];
                den_reg[j] <= den_reg[j-1];
                q_reg[j]   <= q_next[j];
            end
        end
    end

    assign quo = q_reg[DIV_STAGES];

endmodule

// ----- dv/pixel_alpha_blend_tb.sv -----
// Testbench for pixel_alpha_blend: drives RGBA pixel pairs through the
// valid/ready ports and checks each blended pixel against a local predictor.
// Depends on the RTL top module pixel_alpha_blend only.
`timescale 1ns / 1ps

module pixel_alpha_blend_tb;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } rgba_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] bg_red, bg_green, bg_blue, bg_alpha;
    logic [7:0] fg_red, fg_green, fg_blue, fg_alpha;
    logic [7:0] mix_alpha;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_red, out_green, out_blue, out_alpha;

    rgba_t blend_queue[$];
    int    fail_cnt;
    int    idle_cycles;
    bit    calm_mode;
    int    hold_off_cycles;

    pixel_alpha_blend i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .bg_red(bg_red), .bg_green(bg_green), .bg_blue(bg_blue), .bg_alpha(bg_alpha),
        .fg_red(fg_red), .fg_green(fg_green), .fg_blue(fg_blue), .fg_alpha(fg_alpha),
        .mix_alpha(mix_alpha),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .out_alpha(out_alpha)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Over-operator color channel: exact floor, saturated, zero when ac is 0
    function automatic logic [7:0] over_channel(logic [7:0] b, logic [7:0] ba,
                                                 logic [7:0] f, logic [7:0] fa,
                                                 logic [7:0] ac);
        longint unsigned num;
        longint unsigned q;
        if (ac == 0)
            return 8'd0;
        num = 64'd255 * fa * f + 64'd1 * (255 - fa) * ba * b;
        q = num / (64'd255 * ac);
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic rgba_t blend_pixel(rgba_t bg, rgba_t fg, logic [7:0] mix);
        rgba_t     res;
        int unsigned ac;
        if (bg.a == 8'd255 && fg.a == 8'd255)
        begin
            res.r = 8'((mix * fg.r + (255 - mix) * bg.r) / 255);
            res.g = 8'((mix * fg.g + (255 - mix) * bg.g) / 255);
            res.b = 8'((mix * fg.b + (255 - mix) * bg.b) / 255);
            res.a = 8'd255;
        end
        else
        begin
            ac = fg.a + ((255 - fg.a) * bg.a) / 255;
            res.r = over_channel(bg.r, bg.a, fg.r, fg.a, ac[7:0]);
            res.g = over_channel(bg.g, bg.a, fg.g, fg.a, ac[7:0]);
            res.b = over_channel(bg.b, bg.a, fg.b, fg.a, ac[7:0]);
            res.a = ac[7:0];
        end
        return res;
    endfunction

    // Offer one pixel pair, hold until the transfer, then predict its result
    task automatic send_pixel(rgba_t bg, rgba_t fg, logic [7:0] mix);
        int gap;
        if (!calm_mode && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        bg_red <= bg.r; bg_green <= bg.g; bg_blue <= bg.b; bg_alpha <= bg.a;
        fg_red <= fg.r; fg_green <= fg.g; fg_blue <= fg.b; fg_alpha <= fg.a;
        mix_alpha <= mix;
        do
            @(posedge clk);
        while (!in_ready);
        blend_queue.push_back(blend_pixel(bg, fg, mix));
        @(negedge clk);
    endtask

    function automatic rgba_t pick_pixel();
        rgba_t p;
        p.r = 8'($urandom); p.g = 8'($urandom); p.b = 8'($urandom);
        case ($urandom_range(0, 5))
            0: p.a = 8'd255;
            1: p.a = 8'd0;
            2: p.a = 8'($urandom_range(250, 255));
            default: p.a = 8'($urandom);
        endcase
        return p;
    endfunction

    // Drop valid and wait until every predicted pixel has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (blend_queue.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        rgba_t bg, fg;
        bg = '{8'd0, 8'd0, 8'd0, 8'd0};       fg = '{8'd0, 8'd0, 8'd0, 8'd0};
        send_pixel(bg, fg, 8'd0);
        bg = '{8'd255, 8'd255, 8'd255, 8'd0}; fg = '{8'd255, 8'd255, 8'd255, 8'd0};
        send_pixel(bg, fg, 8'd255);
        bg = '{8'd255, 8'd0, 8'd128, 8'd255}; fg = '{8'd0, 8'd255, 8'd127, 8'd255};
        send_pixel(bg, fg, 8'd0);
        send_pixel(bg, fg, 8'd255);
        send_pixel(bg, fg, 8'd128);
        bg = '{8'd255, 8'd255, 8'd255, 8'd255}; fg = '{8'd255, 8'd255, 8'd255, 8'd255};
        send_pixel(bg, fg, 8'd85);
        bg = '{8'd255, 8'd255, 8'd255, 8'd1}; fg = '{8'd255, 8'd255, 8'd255, 8'd254};
        send_pixel(bg, fg, 8'd170);
        bg = '{8'd255, 8'd255, 8'd255, 8'd255}; fg = '{8'd0, 8'd0, 8'd0, 8'd0};
        send_pixel(bg, fg, 8'd200);
        bg = '{8'd10, 8'd200, 8'd90, 8'd0}; fg = '{8'd250, 8'd3, 8'd77, 8'd1};
        send_pixel(bg, fg, 8'd17);
        bg = '{8'd255, 8'd255, 8'd255, 8'd254}; fg = '{8'd255, 8'd255, 8'd255, 8'd255};
        send_pixel(bg, fg, 8'd1);
        bg = '{8'd170, 8'd85, 8'd255, 8'd128}; fg = '{8'd85, 8'd170, 8'd0, 8'd127};
        send_pixel(bg, fg, 8'd254);
        wait_drained();
    endtask

    task automatic test_random(int count);
        repeat (count)
            send_pixel(pick_pixel(), pick_pixel(), 8'($urandom));
    endtask

    // Receiver holds off for a long stretch while pixels keep coming
    task automatic test_backpressure();
        hold_off_cycles = 60;
        test_random(40);
        wait_drained();
    endtask

    // Sender pauses until every result is out, then resumes
    task automatic test_sender_pause();
        test_random(30);
        wait_drained();
        test_random(30);
    endtask

    task automatic test_no_idle();
        calm_mode = 1'b1;
        test_random(200);
        wait_drained();
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else if (idle_cycles > 0)
        begin
            out_ready <= 1'b0;
            idle_cycles <= idle_cycles - 1;
        end
        else if (!calm_mode && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            idle_cycles <= $urandom_range(0, 2);
        end
        else
            out_ready <= 1'b1;
    end

    // Compare each transferred pixel with the oldest prediction
    always @(posedge clk)
    begin
        rgba_t exp_px;
        if (rst_n && out_valid && out_ready)
        begin
            if (blend_queue.size() == 0)
            begin
                $error("unexpected output transfer");
                fail_cnt++;
            end
            else
            begin
                exp_px = blend_queue.pop_front();
                if (out_red !== exp_px.r)
                begin
                    $error("out_red exp %0d got %0d", exp_px.r, out_red);
                    fail_cnt++;
                end
                if (out_green !== exp_px.g)
                begin
                    $error("out_green exp %0d got %0d", exp_px.g, out_green);
                    fail_cnt++;
                end
                if (out_blue !== exp_px.b)
                begin
                    $error("out_blue exp %0d got %0d", exp_px.b, out_blue);
                    fail_cnt++;
                end
                if (out_alpha !== exp_px.a)
                begin
                    $error("out_alpha exp %0d got %0d", exp_px.a, out_alpha);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side, and end the run as a mismatch when it hangs
    int stuck_cnt;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck_cnt <= 0;
        else
            stuck_cnt <= stuck_cnt + 1;
        if (stuck_cnt > 2000)
        begin
            $display("pixel_alpha_blend: mismatch");
            $finish;
        end
    end

    initial
    begin
        fail_cnt = 0;
        idle_cycles = 0;
        hold_off_cycles = 0;
        calm_mode = 1'b0;
        stuck_cnt = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        {bg_red, bg_green, bg_blue, bg_alpha} = '0;
        {fg_red, fg_green, fg_blue, fg_alpha} = '0;
        mix_alpha = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_backpressure();
        test_sender_pause();
        test_random(1000);
        test_no_idle();

        wait_drained();
        repeat (20) @(negedge clk);
        if (fail_cnt == 0)
            $display("pixel_alpha_blend: match");
        else
            $display("pixel_alpha_blend: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/pab_pkg.sv
rtl/core/pab_alpha.sv
rtl/core/pab_lane.sv
rtl/core/pixel_alpha_blend.sv
dv/pixel_alpha_blend_tb.sv
